// File: src/ecpm_pkg.sv
`default_nettype none
package ecpm_pkg;

    localparam int unsigned DEF_NUM_PORTS = 1024;
    localparam int unsigned DEF_WORD_BITS = 32;
    localparam int unsigned DEF_NUM_VCPUS = 4;
    localparam int unsigned DEF_NUM_IRQS  = 256;

    localparam logic [2:0] OP_RAISE    = 3'd0;
    localparam logic [2:0] OP_MASK     = 3'd1;
    localparam logic [2:0] OP_UNMASK   = 3'd2;
    localparam logic [2:0] OP_ACK      = 3'd3;
    localparam logic [2:0] OP_OWNER    = 3'd4;
    localparam logic [2:0] OP_IRQ_MAP  = 3'd5;
    localparam logic [2:0] OP_DISPATCH = 3'd6;
    localparam logic [2:0] OP_NONE     = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [9:0] port;
        logic [1:0] cpu;
        logic [7:0] irq_number;
        logic       irq_valid;
    } cmd_t;

    typedef struct packed {
        logic       found;
        logic [9:0] port_out;
        logic [7:0] irq_out;
        logic       irq_bound;
        logic       upcall_flag;
    } rsp_t;

endpackage
`default_nettype wire

// File: src/ecpm_ram.sv
`default_nettype none
module ecpm_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 8,
    parameter int unsigned AW    = 5
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: src/ecpm_first_set.sv
`default_nettype none
module ecpm_first_set #(
    parameter int unsigned N  = 32,
    parameter int unsigned IW = 5
) (
    input  wire logic [N-1:0]  vec,
    output logic               any,
    output logic      [IW-1:0] idx
);
    always_comb
    begin
        any = |vec;
        idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IW'(i);
            end
        end
    end
endmodule
`default_nettype wire

// File: src/event_channel_pending_mask_dispatcher_core.sv
`default_nettype none
// Event port dispatcher. Pending, mask and owner bits of a whole word of WORD_BITS ports
// sit in one word memory entry; IRQ bindings sit in a per-port memory. Per-CPU word
// selectors and upcall flags are flops. After reset a clearing pass over NUM_PORTS addresses
// initializes both memories, and no item is taken until it ends. A port operation goes
// through word read, modify and write back, then the output step; port zero, an
// out-of-range port or an undefined op skip the modify. A dispatch reads the selected
// word, modifies it and then reads the IRQ memory; each selected word found empty is
// dropped and the scan goes back to the read; with nothing selected it goes to output.
// The next item is accepted only after the result has moved to the output register.
// One item is in work at a time; a finished result waits in an output register while
// the next item is accepted.
module event_channel_pending_mask_dispatcher_core #(
    parameter int unsigned NUM_PORTS = ecpm_pkg::DEF_NUM_PORTS,
    parameter int unsigned WORD_BITS = ecpm_pkg::DEF_WORD_BITS,
    parameter int unsigned NUM_VCPUS = ecpm_pkg::DEF_NUM_VCPUS,
    parameter int unsigned NUM_IRQS  = ecpm_pkg::DEF_NUM_IRQS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire ecpm_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ecpm_pkg::rsp_t     rsp
);
    import ecpm_pkg::*;

    localparam int unsigned NUM_WORDS = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned PW    = $clog2(NUM_PORTS);
    localparam int unsigned WW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned BW    = $clog2(WORD_BITS);
    localparam int unsigned OWN_W = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1;
    localparam int unsigned ENT_W = WORD_BITS * (2 + OWN_W);
    localparam int unsigned CW    = PW + 1;
    localparam int unsigned RSH   = 24;
    localparam int unsigned RECIP = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_IRQ   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    state_reg;
    logic [CW-1:0] clr_cnt_reg;
    cmd_t          cmd_reg;
    logic [WW-1:0] q_reg;
    logic [WW-1:0] w_reg;
    logic [BW-1:0] b_reg;
    logic [9:0]    dport_reg;
    rsp_t          res_reg;
    rsp_t          rsp_reg;
    logic          rsp_valid_reg;
    logic [NUM_WORDS-1:0] sel_reg [NUM_VCPUS];
    logic [NUM_VCPUS-1:0] upcall_reg;

    // word memory
    logic             wm_we, wm_re;
    logic [WW-1:0]    wm_waddr, wm_raddr;
    logic [ENT_W-1:0] wm_wdata, wm_rdata;
    // irq memory
    logic             im_we, im_re;
    logic [PW-1:0]    im_waddr, im_raddr;
    logic [8:0]       im_wdata, im_rdata;

    ecpm_ram #(.DEPTH(NUM_WORDS), .WIDTH(ENT_W), .AW(WW)) u_word_ram (
        .clk(clk), .wr_en(wm_we), .wr_addr(wm_waddr), .wr_data(wm_wdata),
        .rd_en(wm_re), .rd_addr(wm_raddr), .rd_data(wm_rdata)
    );

    ecpm_ram #(.DEPTH(NUM_PORTS), .WIDTH(9), .AW(PW)) u_irq_ram (
        .clk(clk), .wr_en(im_we), .wr_addr(im_waddr), .wr_data(im_wdata),
        .rd_en(im_re), .rd_addr(im_raddr), .rd_data(im_rdata)
    );

    // quotient of the port by the word size via reciprocal multiply
    logic [35:0] q_prod;
    assign q_prod = 36'(cmd.port) * 36'(RECIP);

    logic pok;
    logic cpu_ok;
    logic [OWN_W-1:0] cpu_v;
    assign pok    = (cmd_reg.port != 10'd0) && (32'(cmd_reg.port) < NUM_PORTS);
    assign cpu_ok = 32'(cmd_reg.cpu) < NUM_VCPUS;
    assign cpu_v  = OWN_W'(cmd_reg.cpu);

    logic [NUM_WORDS-1:0] sel_row;
    logic                 sel_any;
    logic [WW-1:0]        sel_idx;
    assign sel_row = cpu_ok ? sel_reg[cpu_v] : '0;

    ecpm_first_set #(.N(NUM_WORDS), .IW(WW)) u_sel_scan (
        .vec(sel_row), .any(sel_any), .idx(sel_idx)
    );

    // unpacked view of the word just read
    logic [WORD_BITS-1:0] pend_w, mask_w;
    logic [OWN_W-1:0]     own_w [WORD_BITS];
    logic [WORD_BITS-1:0] act_w, act_left;
    logic                 act_any, left_any;
    logic [BW-1:0]        act_idx;
    logic [WW-1:0]        cur_w;

    assign cur_w = (cmd_reg.op == OP_DISPATCH) ? w_reg : q_reg;

    always_comb
    begin
        pend_w = wm_rdata[WORD_BITS-1:0];
        mask_w = wm_rdata[2*WORD_BITS-1:WORD_BITS];
        for (int i = 0; i < WORD_BITS; i++)
        begin
            own_w[i] = wm_rdata[2*WORD_BITS + i*OWN_W +: OWN_W];
            act_w[i] = pend_w[i] && !mask_w[i] && (own_w[i] == cpu_v) &&
                       !((w_reg == '0) && (i == 0));
        end
    end

    ecpm_first_set #(.N(WORD_BITS), .IW(BW)) u_bit_scan (
        .vec(act_w), .any(act_any), .idx(act_idx)
    );

    always_comb
    begin
        act_left = act_w;
        act_left[act_idx] = 1'b0;
        left_any = |act_left;
    end

    // update of the addressed bit for port ops, or of the delivered bit for a dispatch
    logic [WORD_BITS-1:0] pend_n, mask_n;
    logic [OWN_W-1:0]     own_n [WORD_BITS];
    logic [OWN_W-1:0]     owner;
    logic                 refire;
    logic [ENT_W-1:0]     ent_mod;

    always_comb
    begin
        pend_n = pend_w;
        mask_n = mask_w;
        own_n  = own_w;
        unique case (cmd_reg.op)
            OP_RAISE:  pend_n[b_reg] = 1'b1;
            OP_MASK:   mask_n[b_reg] = 1'b1;
            OP_UNMASK: mask_n[b_reg] = 1'b0;
            OP_ACK:
            begin
                mask_n[b_reg] = 1'b1;
                pend_n[b_reg] = 1'b0;
            end
            OP_OWNER:
            begin
                if (cpu_ok)
                begin
                    own_n[b_reg] = cpu_v;
                end
            end
            OP_DISPATCH:
            begin
                mask_n[act_idx] = 1'b1;
                pend_n[act_idx] = 1'b0;
            end
            default: ;
        endcase
        owner  = own_w[b_reg];
        refire = ((cmd_reg.op == OP_RAISE) || (cmd_reg.op == OP_UNMASK)) &&
                 pend_n[b_reg] && !mask_n[b_reg] && (32'(owner) < NUM_VCPUS);
        ent_mod[WORD_BITS-1:0]           = pend_n;
        ent_mod[2*WORD_BITS-1:WORD_BITS] = mask_n;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            ent_mod[2*WORD_BITS + i*OWN_W +: OWN_W] = own_n[i];
        end
    end

    logic [15:0] dport_full;
    assign dport_full = 16'(w_reg) * 16'(WORD_BITS) + 16'(act_idx);

    always_comb
    begin
        wm_we    = 1'b0;
        wm_waddr = cur_w;
        wm_wdata = ent_mod;
        wm_re    = 1'b0;
        wm_raddr = q_reg;
        im_we    = 1'b0;
        im_waddr = PW'(cmd_reg.port);
        im_wdata = '0;
        im_re    = 1'b0;
        im_raddr = PW'(dport_full);
        unique case (state_reg)
            S_CLEAR:
            begin
                im_we    = 1'b1;
                im_waddr = PW'(clr_cnt_reg);
                im_wdata = '0;
                if (32'(clr_cnt_reg) < NUM_WORDS)
                begin
                    wm_we    = 1'b1;
                    wm_waddr = WW'(clr_cnt_reg);
                    wm_wdata = '0;
                    wm_wdata[2*WORD_BITS-1:WORD_BITS] = '1;
                end
            end
            S_ADDR:
            begin
                if (cmd_reg.op == OP_DISPATCH)
                begin
                    wm_re    = cpu_ok && sel_any;
                    wm_raddr = sel_idx;
                end
                else
                begin
                    wm_re = pok && (cmd_reg.op != OP_NONE);
                end
            end
            S_MOD:
            begin
                if (cmd_reg.op == OP_DISPATCH)
                begin
                    wm_we = act_any;
                    im_re = act_any;
                end
                else
                begin
                    wm_we = 1'b1;
                    if ((cmd_reg.op == OP_IRQ_MAP) &&
                        (!cmd_reg.irq_valid || (32'(cmd_reg.irq_number) < NUM_IRQS)))
                    begin
                        im_we    = 1'b1;
                        im_wdata = cmd_reg.irq_valid ? {1'b1, cmd_reg.irq_number} : 9'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            upcall_reg    <= '0;
            for (int c = 0; c < NUM_VCPUS; c++)
            begin
                sel_reg[c] <= '0;
            end
            cmd_reg     <= '0;
            q_reg       <= '0;
            w_reg       <= '0;
            b_reg       <= '0;
            dport_reg   <= '0;
            res_reg     <= '0;
            rsp_reg     <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == NUM_PORTS - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        q_reg     <= q_prod[RSH +: WW];
                        state_reg <= S_ADDR;
                    end
                end
                S_ADDR:
                begin
                    b_reg <= BW'(16'(cmd_reg.port) - 16'(q_reg) * 16'(WORD_BITS));
                    if (cmd_reg.op == OP_DISPATCH)
                    begin
                        res_reg <= '0;
                        if (!cpu_ok)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            upcall_reg[cpu_v] <= 1'b0;
                            w_reg <= sel_idx;
                            state_reg <= sel_any ? S_MOD : S_OUT;
                        end
                    end
                    else if (pok && (cmd_reg.op != OP_NONE))
                    begin
                        res_reg <= '0;
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        res_reg <= '{found: 1'b0, port_out: 10'd0, irq_out: 8'd0,
                                     irq_bound: 1'b0,
                                     upcall_flag: cpu_ok && upcall_reg[cpu_v]};
                        state_reg <= S_OUT;
                    end
                end
                S_MOD:
                begin
                    if (cmd_reg.op == OP_DISPATCH)
                    begin
                        if (act_any)
                        begin
                            if (!left_any)
                            begin
                                sel_reg[cpu_v][w_reg] <= 1'b0;
                            end
                            dport_reg <= 10'(dport_full);
                            state_reg <= S_IRQ;
                        end
                        else
                        begin
                            // empty selected word: drop it and scan on
                            sel_reg[cpu_v][w_reg] <= 1'b0;
                            state_reg <= S_ADDR;
                        end
                    end
                    else
                    begin
                        if (refire)
                        begin
                            sel_reg[owner][q_reg] <= 1'b1;
                            upcall_reg[owner]     <= 1'b1;
                        end
                        if (cmd_reg.op == OP_OWNER)
                        begin
                            res_reg.upcall_flag <= cpu_ok && upcall_reg[cpu_v];
                        end
                        else
                        begin
                            res_reg.upcall_flag <= (32'(owner) < NUM_VCPUS) &&
                                                   (upcall_reg[owner] || refire);
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_IRQ:
                begin
                    res_reg.found     <= 1'b1;
                    res_reg.port_out  <= dport_reg;
                    res_reg.irq_bound <= im_rdata[8];
                    res_reg.irq_out   <= im_rdata[8] ? im_rdata[7:0] : 8'd0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_found_port_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.found || rsp.port_out != 10'd0))
        else $error("delivered port zero");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.port_out == 10'd0 && !rsp.irq_bound))
        else $error("empty dispatch carries a port");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> cmd_stall)
        else $error("item taken during clearing pass");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wm_we && wm_re))
        else $error("word memory read and write in one cycle");

    a_dispatch_clears_upcall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IRQ) |=> (!res_reg.upcall_flag))
        else $error("dispatch left upcall flag set");
endmodule
`default_nettype wire

// File: test/tb_event_channel_pending_mask_dispatcher_core.sv
`default_nettype none
module tb_event_channel_pending_mask_dispatcher_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ecpm_pkg::*;

    localparam int NPORTS = DEF_NUM_PORTS;
    localparam int WBITS  = DEF_WORD_BITS;
    localparam int NCPUS  = DEF_NUM_VCPUS;
    localparam int NIRQS  = DEF_NUM_IRQS;
    localparam int NWORDS = NPORTS / WBITS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    event_channel_pending_mask_dispatcher_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // shadow copy of the dispatcher state
    logic       pend_q [NPORTS];
    logic       mask_q [NPORTS];
    logic [1:0] owner_q [NPORTS];
    logic [8:0] irq_q [NPORTS];
    logic       sel_q [NCPUS][NWORDS];
    logic       upcall_q [NCPUS];

    rsp_t expected_rsps[$];
    int   mismatches;
    int   rsp_count;
    int   cmd_count;
    int   dispatch_hits;
    int   idle_cycles;
    bit   sender_idle_en;
    bit   receiver_idle_en;
    bit   hold_receiver;
    int   hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_active(int p, int c);
        return p != 0 && pend_q[p] && !mask_q[p] && owner_q[p] == c;
    endfunction

    function automatic int first_active(int w, int c);
        for (int b = 0; b < WBITS; b++)
        begin
            if (is_active(w * WBITS + b, c))
                return w * WBITS + b;
        end
        return 0;
    endfunction

    function automatic void mark_selected(int p);
        int o;
        o = owner_q[p];
        if (pend_q[p] && !mask_q[p])
        begin
            sel_q[o][p / WBITS] = 1'b1;
            upcall_q[o] = 1'b1;
        end
    endfunction

    function automatic rsp_t predict_event(cmd_t c);
        rsp_t r;
        int addr;
        int p;
        int q;
        r = '0;
        addr = c.cpu;
        p = c.port;
        if (c.op <= OP_IRQ_MAP)
        begin
            if (p != 0)
            begin
                case (c.op)
                    OP_RAISE:
                    begin
                        pend_q[p] = 1'b1;
                        mark_selected(p);
                    end
                    OP_MASK: mask_q[p] = 1'b1;
                    OP_UNMASK:
                    begin
                        mask_q[p] = 1'b0;
                        mark_selected(p);
                    end
                    OP_ACK:
                    begin
                        mask_q[p] = 1'b1;
                        pend_q[p] = 1'b0;
                    end
                    OP_OWNER: owner_q[p] = c.cpu;
                    default:
                    begin
                        if (!c.irq_valid)
                            irq_q[p] = '0;
                        else if (c.irq_number < NIRQS)
                            irq_q[p] = {1'b1, c.irq_number};
                    end
                endcase
                if (c.op != OP_OWNER)
                    addr = owner_q[p];
            end
        end
        else if (c.op == OP_DISPATCH)
        begin
            upcall_q[c.cpu] = 1'b0;
            for (int w = 0; w < NWORDS; w++)
            begin
                if (!sel_q[c.cpu][w])
                    continue;
                q = first_active(w, c.cpu);
                if (q == 0)
                begin
                    sel_q[c.cpu][w] = 1'b0;
                    continue;
                end
                r.found = 1'b1;
                r.port_out = q[9:0];
                if (irq_q[q][8])
                begin
                    r.irq_bound = 1'b1;
                    r.irq_out = irq_q[q][7:0];
                end
                mask_q[q] = 1'b1;
                pend_q[q] = 1'b0;
                if (first_active(w, c.cpu) == 0)
                    sel_q[c.cpu][w] = 1'b0;
                break;
            end
        end
        r.upcall_flag = upcall_q[addr];
        return r;
    endfunction

    task automatic send_event_cmd(cmd_t c);
        int gap;
        if (sender_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        expected_rsps.push_back(predict_event(c));
        cmd_count++;
    endtask

    task automatic finish_sending();
        cmd_valid <= 1'b0;
    endtask

    function automatic cmd_t make_cmd(logic [2:0] op, int p, int c, int irq, bit v);
        cmd_t x;
        x.op = op;
        x.port = p[9:0];
        x.cpu = c[1:0];
        x.irq_number = irq[7:0];
        x.irq_valid = v;
        return x;
    endfunction

    task automatic wait_drained();
        while (expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall bursts, or a long hold when asked
    initial
    begin
        int burst;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_receiver = 1'b0;
            end
            else if (receiver_idle_en && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 11);
                rsp_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // result checker
    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", rsp);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (want.found != rsp.found || want.port_out != rsp.port_out ||
                        want.irq_out != rsp.irq_out || want.irq_bound != rsp.irq_bound ||
                        want.upcall_flag != rsp.upcall_flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %p got %p", rsp_count, want, rsp);
                    end
                    else if (want.found)
                        dispatch_hits++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else if (rst_n)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired");
                $display("event_channel_pending_mask_dispatcher_core: mismatch");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_event_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0));
        send_event_cmd(make_cmd(OP_RAISE, 0, 0, 0, 0));
        send_event_cmd(make_cmd(OP_UNMASK, 0, 0, 0, 0));
        send_event_cmd(make_cmd(OP_IRQ_MAP, 1023, 0, 255, 1));
        send_event_cmd(make_cmd(OP_OWNER, 1023, 3, 0, 0));
        send_event_cmd(make_cmd(OP_RAISE, 1023, 0, 0, 0));
        send_event_cmd(make_cmd(OP_UNMASK, 1023, 1, 0, 0));
        send_event_cmd(make_cmd(OP_RAISE, 1, 0, 0, 0));
        send_event_cmd(make_cmd(OP_UNMASK, 1, 0, 0, 0));
        send_event_cmd(make_cmd(OP_RAISE, 2, 0, 0, 0));
        send_event_cmd(make_cmd(OP_UNMASK, 2, 0, 0, 0));
        send_event_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0));
        send_event_cmd(make_cmd(OP_MASK, 2, 0, 0, 0));
        send_event_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0));
        send_event_cmd(make_cmd(OP_DISPATCH, 0, 3, 0, 0));
        send_event_cmd(make_cmd(OP_IRQ_MAP, 40, 0, 170, 1));
        send_event_cmd(make_cmd(OP_IRQ_MAP, 40, 0, 85, 0));
        send_event_cmd(make_cmd(OP_RAISE, 40, 0, 0, 0));
        send_event_cmd(make_cmd(OP_ACK, 40, 0, 0, 0));
        send_event_cmd(make_cmd(OP_NONE, 5, 2, 0, 0));
        send_event_cmd(make_cmd(OP_DISPATCH, 0, 0, 0, 0));
    endtask

    // a focused burst on a few ports so dispatch finds something
    task automatic test_random(int n);
        int p;
        int r;
        int base;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            base = $urandom_range(0, 3) * 256;
            if (r < 85)
                p = base + $urandom_range(0, 40);
            else
                p = $urandom_range(0, 1023);
            if (r < 3)
                send_event_cmd(make_cmd(OP_NONE, p, int'($urandom_range(0, 3)),
                                        int'($urandom_range(0, 255)), 1'($urandom)));
            else
                send_event_cmd(make_cmd(3'($urandom_range(0, 6)), p,
                                        int'($urandom_range(0, 3)),
                                        int'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_receiver = 1'b1;
        test_random(40);
        finish_sending();
        wait_drained();
        repeat (20) @(posedge clk);
        test_random(20);
    endtask

    initial
    begin
        int drain_wait;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        mismatches = 0;
        rsp_count = 0;
        cmd_count = 0;
        dispatch_hits = 0;
        hold_receiver = 1'b0;
        hold_cycles = 0;
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
        for (int i = 0; i < NPORTS; i++)
        begin
            pend_q[i] = 1'b0;
            mask_q[i] = 1'b1;
            owner_q[i] = '0;
            irq_q[i] = '0;
        end
        for (int c = 0; c < NCPUS; c++)
        begin
            upcall_q[c] = 1'b0;
            for (int w = 0; w < NWORDS; w++)
                sel_q[c][w] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(900);
        test_backpressure();
        test_random(300);
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        test_random(150);
        finish_sending();

        drain_wait = 0;
        while (expected_rsps.size() != 0 && drain_wait < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);
        if (expected_rsps.size() != 0)
            mismatches++;

        $display("sent %0d commands, checked %0d results, %0d dispatches delivered a port",
                 cmd_count, rsp_count, dispatch_hits);
        $display("mismatches: %0d, including backpressure and undefined ops", mismatches);
        if (mismatches == 0)
            $display("event_channel_pending_mask_dispatcher_core: match");
        else
            $display("event_channel_pending_mask_dispatcher_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
